FILE: sv/plda_pkg.sv
// ----------------------------------------------------------------------------
// plda_pkg
// Shared types and constants of the piecewise-linear distribution mapper.
// ----------------------------------------------------------------------------
package plda_pkg;

    localparam int VAL_W     = 12;
    localparam int CUM_W     = 28;
    localparam int PROB_W    = 16;
    localparam int STAT_W    = 3;
    localparam int FUNC_W    = 2;
    localparam int COUNT_O_W = 6;

    // Multiplier operand and product widths.
    localparam int MUL_A_W = CUM_W;
    localparam int MUL_B_W = VAL_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Divider: dividend is offset times value span, divisor is a cumulative span.
    localparam int DIV_W     = CUM_W + VAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [CUM_W-1:0] SUM_MAX = {CUM_W{1'b1}};

    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLOSE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_MAP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STAT_W-1:0] ST_ORDER = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd4;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [CUM_W-1:0] cum;
    } t_entry;

endpackage

FILE: sv/piecewise_linear_distribution_mapper.sv
// ----------------------------------------------------------------------------
// piecewise_linear_distribution_mapper
// Builds a piecewise-linear cumulative table and maps uniform numbers onto it.
// ----------------------------------------------------------------------------
// The block takes one operation per input transfer and returns exactly one
// result transfer for it. It works on one operation at a time and holds
// o_stall high from acceptance until the result has been written to the
// output register; a finished result may wait there while the next
// operation is accepted. Clear and close go from the execute state to
// the finish state; a valid append adds a multiply and a sum state. A
// map runs a binary search whose steps each take a search and a compare
// state because the table read is registered, reads both bracket
// entries, multiplies, and forms the interpolation quotient in the
// serial divider one bit per cycle, 40 bits in all. One multiplier is
// shared by the trapezoid area of an append and the interpolation
// product of a map. The table memory has no reset; entries beyond the
// fill count are never used. The max_value register sits at APB byte
// address 0 and may only be written while the block is idle.
// ----------------------------------------------------------------------------
module piecewise_linear_distribution_mapper import plda_pkg::*; #(
    parameter int MAX_POINTS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Operation input channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [VAL_W-1:0]     i_point_value,
    input  logic [PROB_W-1:0]    i_point_prob,
    input  logic [CUM_W-1:0]     i_uniform_in,

    // Result output channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [VAL_W-1:0]     o_mapped_value,
    output logic [CUM_W-1:0]     o_total_sum,
    output logic [COUNT_O_W-1:0] o_entry_count,
    output logic [STAT_W-1:0]    o_status,

    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DEPTH = MAX_POINTS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] ADDR_MAX_VALUE = 2'd0;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_ADD_MUL = 4'd2;
    localparam logic [3:0] S_ADD_SUM = 4'd3;
    localparam logic [3:0] S_SRCH    = 4'd4;
    localparam logic [3:0] S_CMP     = 4'd5;
    localparam logic [3:0] S_RLO     = 4'd6;
    localparam logic [3:0] S_RHI     = 4'd7;
    localparam logic [3:0] S_PREP    = 4'd8;
    localparam logic [3:0] S_MUL     = 4'd9;
    localparam logic [3:0] S_DIVST   = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    // Control state.
    logic [3:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CUM_W-1:0]        r_sum, n_sum;
    logic signed [VAL_W:0]   r_prev_value, n_prev_value;
    logic [PROB_W-1:0]       r_prev_prob, n_prev_prob;
    logic [VAL_W-1:0]        r_max;
    logic                    r_out_valid, n_out_valid;

    // Captured operation.
    logic [FUNC_W-1:0]       r_func;
    logic [VAL_W-1:0]        r_pv;
    logic [PROB_W-1:0]       r_pp;
    logic [CUM_W-1:0]        r_u;

    // Working registers.
    logic [AW-1:0]           r_lo, n_lo;
    logic [AW-1:0]           r_hi, n_hi;
    logic [AW-1:0]           r_mid, n_mid;
    logic [VAL_W-1:0]        r_lo_val, n_lo_val;
    logic [CUM_W-1:0]        r_lo_cum, n_lo_cum;
    logic [MUL_A_W-1:0]      r_op_a, n_op_a;
    logic [MUL_B_W-1:0]      r_op_b, n_op_b;
    logic [CUM_W-1:0]        r_pd, n_pd;
    logic [VAL_W-1:0]        r_mapped, n_mapped;
    logic [STAT_W-1:0]       r_status, n_status;

    // Output register.
    logic [VAL_W-1:0]        r_o_mapped;
    logic [CUM_W-1:0]        r_o_sum;
    logic [COUNT_O_W-1:0]    r_o_count;
    logic [STAT_W-1:0]       r_o_status;
    logic                    out_load;

    // Table, multiplier and divider connections.
    logic                    tab_we;
    logic [AW-1:0]           tab_waddr;
    t_entry                  tab_wdata;
    logic [AW-1:0]           tab_raddr;
    t_entry                  tab_rdata;
    logic [MUL_P_W-1:0]      mul_prod;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quo;

    // Helper signals.
    logic                    in_accept;
    logic                    cfg_write;
    logic signed [VAL_W:0]   pv_s;
    logic signed [VAL_W:0]   max_s;
    logic                    need_two;
    logic [CW:0]             count_need;
    logic signed [VAL_W:0]   base_value;
    logic [AW:0]             span;
    logic [AW:0]             mid_sum;
    logic [CW-1:0]           count_m1;
    logic [CUM_W:0]          sum_ext;
    logic [PROB_W:0]         prob_sum;
    logic [VAL_W:0]          map_sum;

    plda_tab #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    plda_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_op_a),
        .i_b    (r_op_b),
        .o_prod (mul_prod)
    );

    plda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod[DIV_W-1:0]),
        .i_divisor  (r_pd),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Configuration: a single read/write register, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_MAX_VALUE);
    assign prdata    = (paddr == ADDR_MAX_VALUE) ? {{(32 - VAL_W){1'b0}}, r_max} : '0;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;

    assign pv_s       = $signed({1'b0, r_pv});
    assign max_s      = $signed({1'b0, r_max});
    assign need_two   = (r_count == '0) && (r_pv != '0);
    assign count_need = {1'b0, r_count} + (need_two ? (CW + 1)'(2) : (CW + 1)'(1));
    // When a (0,0) entry is inserted first, the segment starts at zero.
    assign base_value = need_two ? '0 : r_prev_value;
    assign span       = {1'b0, r_hi} - {1'b0, r_lo};
    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign count_m1   = r_count - 1'b1;
    assign sum_ext    = {1'b0, r_sum} + (CUM_W + 1)'(mul_prod[MUL_P_W-1:1]);
    assign prob_sum   = {1'b0, r_prev_prob} + {1'b0, r_pp};
    assign map_sum    = {1'b0, r_lo_val} + {1'b0, div_quo[VAL_W-1:0]};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sum        = r_sum;
        n_prev_value = r_prev_value;
        n_prev_prob  = r_prev_prob;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_lo_val     = r_lo_val;
        n_lo_cum     = r_lo_cum;
        n_op_a       = r_op_a;
        n_op_b       = r_op_b;
        n_pd         = r_pd;
        n_mapped     = r_mapped;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        tab_we       = 1'b0;
        tab_waddr    = r_count[AW-1:0];
        tab_wdata    = '0;
        tab_raddr    = r_lo;
        div_start    = 1'b0;
        out_load     = 1'b0;

        // The pending result leaves on its output transfer.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_mapped = '0;
                n_status = ST_OK;
                n_state  = S_FIN;
                case (r_func)
                    FN_CLEAR: begin
                        n_count      = '0;
                        n_sum        = '0;
                        n_prev_value = '1;
                        n_prev_prob  = '0;
                    end
                    FN_APPEND: begin
                        if (pv_s == r_prev_value) begin
                            n_status = ST_DUP;
                        end else if (pv_s < r_prev_value) begin
                            n_status = ST_ORDER;
                        end else if (count_need > (CW + 1)'(DEPTH - 1)) begin
                            n_status = ST_FULL;
                        end else begin
                            if (need_two) begin
                                // Anchor the curve at value zero.
                                tab_we       = 1'b1;
                                tab_wdata    = '0;
                                n_count      = r_count + 1'b1;
                                n_prev_value = '0;
                            end
                            n_op_a  = MUL_A_W'(prob_sum);
                            n_op_b  = MUL_B_W'(pv_s - base_value);
                            n_state = S_ADD_MUL;
                        end
                    end
                    FN_CLOSE: begin
                        if (max_s == r_prev_value) begin
                            n_status = ST_OK;
                        end else if (max_s < r_prev_value) begin
                            n_status = ST_ORDER;
                        end else if (r_count >= CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            tab_we        = 1'b1;
                            tab_wdata.val = r_max;
                            tab_wdata.cum = r_sum;
                            n_count       = r_count + 1'b1;
                            n_prev_value  = max_s;
                            n_prev_prob   = '0;
                        end
                    end
                    FN_MAP: begin
                        if ((r_u >= r_sum) || (r_count == '0)) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_lo    = '0;
                            n_hi    = count_m1[AW-1:0];
                            n_state = S_SRCH;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end

            S_ADD_MUL: begin
                // The multiplier registers the unhalved area this cycle.
                n_state = S_ADD_SUM;
            end

            S_ADD_SUM: begin
                n_sum         = sum_ext[CUM_W] ? SUM_MAX : sum_ext[CUM_W-1:0];
                tab_we        = 1'b1;
                tab_wdata.val = r_pv;
                tab_wdata.cum = n_sum;
                n_count       = r_count + 1'b1;
                n_prev_prob   = r_pp;
                n_prev_value  = pv_s;
                n_state       = S_FIN;
            end

            S_SRCH: begin
                if (span > (AW + 1)'(1)) begin
                    n_mid     = mid_sum[AW:1];
                    tab_raddr = mid_sum[AW:1];
                    n_state   = S_CMP;
                end else begin
                    tab_raddr = r_lo;
                    n_state   = S_RLO;
                end
            end

            S_CMP: begin
                if (tab_rdata.cum < r_u) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH;
            end

            S_RLO: begin
                // The lower bracket entry is on the read port; fetch the upper one.
                n_lo_val  = tab_rdata.val;
                n_lo_cum  = tab_rdata.cum;
                tab_raddr = r_hi;
                n_state   = S_RHI;
            end

            S_RHI: begin
                // Keep the upper bracket entry on the read port for the next cycle.
                tab_raddr = r_hi;
                n_state   = S_PREP;
            end

            S_PREP: begin
                // A flat cumulative span divides by one.
                if (tab_rdata.cum > r_lo_cum) begin
                    n_pd = tab_rdata.cum - r_lo_cum;
                end else begin
                    n_pd = CUM_W'(1);
                end
                if (tab_rdata.val > r_lo_val) begin
                    n_op_b = {1'b0, tab_rdata.val - r_lo_val};
                end else begin
                    n_op_b = '0;
                end
                if (r_u > r_lo_cum) begin
                    n_op_a = r_u - r_lo_cum;
                end else begin
                    n_op_a = '0;
                end
                n_state = S_MUL;
            end

            S_MUL: begin
                n_state = S_DIVST;
            end

            S_DIVST: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end

            S_DIV: begin
                if (div_done) begin
                    if ((div_quo[DIV_W-1:VAL_W] != '0) || map_sum[VAL_W]) begin
                        n_mapped = VAL_MAX;
                    end else begin
                        n_mapped = map_sum[VAL_W-1:0];
                    end
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_sum        <= '0;
            r_prev_value <= '1;
            r_prev_prob  <= '0;
            r_max        <= VAL_MAX;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_sum        <= n_sum;
            r_prev_value <= n_prev_value;
            r_prev_prob  <= n_prev_prob;
            r_out_valid  <= n_out_valid;
            if (cfg_write) begin
                r_max <= pwdata[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= i_func;
            r_pv   <= i_point_value;
            r_pp   <= i_point_prob;
            r_u    <= i_uniform_in;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_lo_val <= n_lo_val;
        r_lo_cum <= n_lo_cum;
        r_op_a   <= n_op_a;
        r_op_b   <= n_op_b;
        r_pd     <= n_pd;
        r_mapped <= n_mapped;
        r_status <= n_status;
        if (out_load) begin
            r_o_mapped <= r_mapped;
            r_o_sum    <= r_sum;
            r_o_count  <= COUNT_O_W'(r_count);
            r_o_status <= r_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_value = r_o_mapped;
    assign o_total_sum    = r_o_sum;
    assign o_entry_count  = r_o_count;
    assign o_status       = r_o_status;

endmodule

FILE: sv/plda_tab.sv
// ----------------------------------------------------------------------------
// plda_tab
// Curve table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module plda_tab import plda_pkg::*; #(
    parameter int DEPTH = 34,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/plda_mul.sv
// ----------------------------------------------------------------------------
// plda_mul
// Shared registered multiplier for trapezoid areas and interpolation products.
// ----------------------------------------------------------------------------
module plda_mul import plda_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/plda_div.sv
// ----------------------------------------------------------------------------
// plda_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plda_div import plda_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [CUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [CUM_W-1:0]     r_rem;
    logic [CUM_W-1:0]     r_dsr;

    logic [CUM_W:0] trial;
    logic [CUM_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of the quotient register while
    // quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[CUM_W-1:0] : trial[CUM_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
